// ===== rtl/core/fate_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fate_pkg
// shared constants, types and helpers of the flow aggregation table
// ----------------------------------------------------------------------------
package fate_pkg;

    // table geometry; bucket count must be a power of two (bucket = low id bits)
    localparam int BUCKETS     = 1024;
    localparam int BUCKET_BITS = $clog2(BUCKETS);
    localparam int WAYS        = 16;
    localparam int WAY_BITS    = $clog2(WAYS);
    localparam int FILL_BITS   = WAY_BITS + 1;

    localparam int KEY_W       = 32;
    localparam int COUNT_W     = 32;
    localparam int STAMP_W     = 32;
    // stamps at or above 2**STAMP_LIM_BITS never win the lru pick
    localparam int STAMP_LIM_BITS = 30;

    localparam int S_TDATA_W   = 32;
    localparam int OUTCOME_W   = 2;
    localparam int M_TDATA_W   = ((OUTCOME_W + KEY_W + 7) / 8) * 8;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_HIT    = 2'd0,
        OUT_INSERT = 2'd1,
        OUT_EVICT  = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } way_t;

    // one bucket: fill count plus all ways, read and written as one row
    typedef struct packed {
        logic [FILL_BITS-1:0] fill;
        way_t [WAYS-1:0]      ways;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    // lru candidate: stamp below limit, its low bits and its way
    typedef struct packed {
        logic                      valid;
        logic [STAMP_LIM_BITS-1:0] stamp;
        logic [WAY_BITS-1:0]       idx;
    } cand_t;

    localparam int CAND_L2 = WAYS / 4;

    // lookup stage result handed to the write-back stage
    typedef struct packed {
        logic                 hit;
        logic [WAY_BITS-1:0]  hit_way;
        logic [FILL_BITS-1:0] fill;
        cand_t [CAND_L2-1:0]  cand;
    } lookup_t;

    // lower way (a) wins unless b is valid and either a is not or b is strictly older
    function automatic cand_t lru_merge(input cand_t a, input cand_t b);
        cand_t r;
        if (b.valid && (!a.valid || (b.stamp < a.stamp))) begin
            r = b;
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/fate_row_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fate_row_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fate_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/fate_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fate_lookup
// key compare over one bucket row and first two levels of the lru tree
// ----------------------------------------------------------------------------
module fate_lookup (
    input  logic                        aclk,
    input  logic                        en,
    input  fate_pkg::row_t              row,
    input  logic [fate_pkg::KEY_W-1:0]  flow_id,
    output fate_pkg::lookup_t           result
);

    logic [fate_pkg::WAYS-1:0]     match;
    logic                          hit;
    logic [fate_pkg::WAY_BITS-1:0] hit_way;
    fate_pkg::cand_t               leaf [fate_pkg::WAYS];
    fate_pkg::cand_t               lvl1 [fate_pkg::WAYS/2];
    fate_pkg::lookup_t             result_next;
    fate_pkg::lookup_t             result_reg;

    always_comb begin
        for (int w = 0; w < fate_pkg::WAYS; w++) begin
            match[w] = (row.ways[w].key == flow_id);
        end
    end

    // lowest matching way
    always_comb begin
        hit     = |match;
        hit_way = '0;
        for (int w = fate_pkg::WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_way = fate_pkg::WAY_BITS'(w);
            end
        end
    end

    always_comb begin
        for (int w = 0; w < fate_pkg::WAYS; w++) begin
            leaf[w].valid = (row.ways[w].stamp[fate_pkg::STAMP_W-1:fate_pkg::STAMP_LIM_BITS]
                             == '0);
            leaf[w].stamp = row.ways[w].stamp[fate_pkg::STAMP_LIM_BITS-1:0];
            leaf[w].idx   = fate_pkg::WAY_BITS'(w);
        end
        for (int i = 0; i < fate_pkg::WAYS / 2; i++) begin
            lvl1[i] = fate_pkg::lru_merge(leaf[2*i], leaf[2*i+1]);
        end
    end

    always_comb begin
        result_next.hit     = hit;
        result_next.hit_way = hit_way;
        result_next.fill    = row.fill;
        for (int i = 0; i < fate_pkg::CAND_L2; i++) begin
            result_next.cand[i] = fate_pkg::lru_merge(lvl1[2*i], lvl1[2*i+1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/core/flow_aggregation_table_with_eviction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_aggregation_table_with_eviction
// set-associative flow counter table with round-robin or lru eviction
// ----------------------------------------------------------------------------
// each request carries a 32-bit flow id; its low bits pick one of 1024 buckets
// of 16 ways (key, 32-bit count, use stamp). a hit bumps the count of the
// lowest matching way, a miss fills the next free way with count 1, and a miss
// in a full bucket replaces a victim and reports the old key. eviction_mode 0
// takes the victim from one global round-robin pointer, mode 1 the way with
// the oldest stamp below 2**30 (way 0 if none). keys start at zero, so flow
// id 0 matches an empty way. after reset the block clears the table row by
// row (s_tready low); configuration writes are taken at any time. each
// request then passes through bucket row read from the ram, key compare and
// lru tree, then row write-back and result, which waits until the output
// register can take it; the single ram row holding a whole bucket is read
// and written once per request, so a new request is taken only once the last
// is written back, while results drain through an output register
// ----------------------------------------------------------------------------
module flow_aggregation_table_with_eviction (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input requests
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fate_pkg::S_TDATA_W-1:0] s_tdata,   // [31:0] flow_id
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fate_pkg::M_TDATA_W-1:0] m_tdata,   // [1:0] outcome, [33:2] evicted_key
    // configuration
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data   // eviction_mode
);

    // state machine and control
    fate_pkg::state_t                 state_reg, state_next;
    logic [fate_pkg::BUCKET_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic [fate_pkg::KEY_W-1:0]       id_reg;
    logic [fate_pkg::STAMP_W-1:0]     clock_reg;
    logic [fate_pkg::WAY_BITS-1:0]    rr_ptr_reg;
    logic                             mode_reg;

    // output register
    logic                             m_valid_reg;
    logic [fate_pkg::M_TDATA_W-1:0]   m_data_reg;
    logic                             out_free;

    // ram ports
    logic                             ram_we, ram_re;
    logic [fate_pkg::BUCKET_BITS-1:0] ram_waddr;
    logic [fate_pkg::ROW_W-1:0]       ram_wdata, ram_rdata;
    fate_pkg::row_t                   cur_row, new_row;

    // lookup stage
    fate_pkg::lookup_t                lk;
    logic                             accept, commit;

    // write-back decision
    fate_pkg::cand_t                  lvl3 [2];
    fate_pkg::cand_t                  root;
    logic [fate_pkg::WAY_BITS-1:0]    lru_way;
    logic                             full;
    logic [fate_pkg::WAY_BITS-1:0]    sel_way;
    fate_pkg::outcome_t               outcome;
    logic [fate_pkg::KEY_W-1:0]       evicted_key;
    logic [fate_pkg::STAMP_W-1:0]     clock_new;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign cur_row   = fate_pkg::row_t'(ram_rdata);

    fate_row_ram #(
        .DEPTH (fate_pkg::BUCKETS),
        .WIDTH (fate_pkg::ROW_W)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (s_tdata[fate_pkg::BUCKET_BITS-1:0]),
        .rdata (ram_rdata)
    );

    fate_lookup u_lookup (
        .aclk    (aclk),
        .en      (state_reg == fate_pkg::ST_LOOK),
        .row     (cur_row),
        .flow_id (id_reg),
        .result  (lk)
    );

    // finish lru tree; no candidate below the limit falls back to way 0
    always_comb begin
        lvl3[0] = fate_pkg::lru_merge(lk.cand[0], lk.cand[1]);
        lvl3[1] = fate_pkg::lru_merge(lk.cand[2], lk.cand[3]);
        root    = fate_pkg::lru_merge(lvl3[0], lvl3[1]);
        lru_way = root.valid ? root.idx : '0;
    end

    // hit, insert into next free way, or evict
    always_comb begin
        full      = (lk.fill >= fate_pkg::FILL_BITS'(fate_pkg::WAYS));
        clock_new = clock_reg + 1'b1;
        if (lk.hit) begin
            outcome = fate_pkg::OUT_HIT;
            sel_way = lk.hit_way;
        end else if (!full) begin
            outcome = fate_pkg::OUT_INSERT;
            sel_way = lk.fill[fate_pkg::WAY_BITS-1:0];
        end else begin
            outcome = fate_pkg::OUT_EVICT;
            sel_way = mode_reg ? lru_way : rr_ptr_reg;
        end
        evicted_key = (outcome == fate_pkg::OUT_EVICT) ? cur_row.ways[sel_way].key : '0;

        new_row = cur_row;
        new_row.ways[sel_way].key   = id_reg;
        new_row.ways[sel_way].count = lk.hit ? cur_row.ways[sel_way].count + 1'b1
                                             : fate_pkg::COUNT_W'(1);
        new_row.ways[sel_way].stamp = clock_new;
        if (outcome == fate_pkg::OUT_INSERT) begin
            new_row.fill = lk.fill + 1'b1;
        end
    end

    // next state and ram control
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        s_tready      = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = id_reg[fate_pkg::BUCKET_BITS-1:0];
        ram_wdata     = new_row;
        commit        = 1'b0;
        case (state_reg)
            fate_pkg::ST_CLEAR: begin
                // one row a cycle back to all zero
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == fate_pkg::BUCKET_BITS'(fate_pkg::BUCKETS - 1)) begin
                    state_next = fate_pkg::ST_IDLE;
                end
            end
            fate_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                ram_re   = s_tvalid;
                if (s_tvalid) begin
                    state_next = fate_pkg::ST_LOOK;
                end
            end
            fate_pkg::ST_LOOK: begin
                state_next = fate_pkg::ST_WRITE;
            end
            fate_pkg::ST_WRITE: begin
                // hold until the output register can take the result
                if (out_free) begin
                    ram_we     = 1'b1;
                    commit     = 1'b1;
                    state_next = fate_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fate_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fate_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            id_reg <= s_tdata;
        end
    end

    // use clock, round-robin pointer and mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_reg  <= '0;
            rr_ptr_reg <= '0;
            mode_reg   <= 1'b0;
        end else begin
            if (commit) begin
                clock_reg <= clock_new;
                if (outcome == fate_pkg::OUT_EVICT && !mode_reg) begin
                    rr_ptr_reg <= rr_ptr_reg + 1'b1;
                end
            end
            if (cfg_valid) begin
                mode_reg <= cfg_data;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= fate_pkg::M_TDATA_W'({evicted_key, outcome});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/core/fate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fate_checker
// port-level checks of the flow aggregation table, bound to the top level
// ----------------------------------------------------------------------------
module fate_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [fate_pkg::M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in flight");

    // outcome code is one of hit, insert, evict
    a_outcome_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[fate_pkg::OUTCOME_W-1:0] == fate_pkg::OUT_HIT)
                  || (m_tdata[fate_pkg::OUTCOME_W-1:0] == fate_pkg::OUT_INSERT)
                  || (m_tdata[fate_pkg::OUTCOME_W-1:0] == fate_pkg::OUT_EVICT))
        else $error("undefined outcome code");

    // key only reported on eviction, padding zero
    a_key_on_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[fate_pkg::OUTCOME_W-1:0] != fate_pkg::OUT_EVICT)
        |-> m_tdata[fate_pkg::M_TDATA_W-1:fate_pkg::OUTCOME_W] == '0)
        else $error("evicted key without eviction");

endmodule

bind flow_aggregation_table_with_eviction fate_checker u_fate_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
